/* sv/ppmt_pkg.sv */
// Shared types and constants for the priority pair match table.
package ppmt_pkg;

  localparam int CMD_W   = 3;
  localparam int SCORE_W = 32;
  localparam int DELTA_W = SCORE_W + 1;
  localparam int SUM_W   = 48;

  // Command codes carried in the cmd field
  typedef enum logic [CMD_W-1:0] {
    CMD_PADD       = 3'd0,
    CMD_APPEND     = 3'd1,
    CMD_FIND_SCENE = 3'd2,
    CMD_FIND_MODEL = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_t;

  // Entry update broadcast to every cell
  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_SHIFT
  } cell_op_t;

  // Controller sequence
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DECIDE,
    ST_WRITE,
    ST_SHIFT,
    ST_DONE
  } state_t;

  // Search token flags handed from cell to cell
  typedef struct packed {
    logic stop;
    logic can;
    logic has_s;
    logic has_m;
    logic found;
  } tok_flags_t;

  localparam tok_flags_t TOK_INIT = '{stop: 1'b0, can: 1'b1, has_s: 1'b0,
                                      has_m: 1'b0, found: 1'b0};

endpackage

/* sv/ppmt_in_if.sv */
// Command channel: valid/ready handshake with one command and its pair.
interface ppmt_in_if #(
  parameter int IDX_W = 16
);
  logic                                 valid;
  logic                                 ready;
  logic [ppmt_pkg::CMD_W-1:0]           cmd;
  logic [IDX_W-1:0]                     model_index;
  logic [IDX_W-1:0]                     scene_index;
  logic signed [ppmt_pkg::SCORE_W-1:0]  pair_score;
  logic signed [ppmt_pkg::SCORE_W-1:0]  pair_priority;

  modport source (output valid, cmd, model_index, scene_index, pair_score, pair_priority,
                  input ready);
  modport sink   (input valid, cmd, model_index, scene_index, pair_score, pair_priority,
                  output ready);
endinterface

/* sv/ppmt_out_if.sv */
// Result channel: valid/ready handshake with one result per command.
interface ppmt_out_if #(
  parameter int IDX_W = 16,
  parameter int CNT_W = 9
);
  logic                                valid;
  logic                                ready;
  logic                                accepted;
  logic                                found;
  logic [IDX_W-1:0]                    partner_index;
  logic [CNT_W-1:0]                    pair_count;
  logic signed [ppmt_pkg::SUM_W-1:0]   total_score;
  logic                                table_full;

  modport source (output valid, accepted, found, partner_index, pair_count, total_score,
                  table_full, input ready);
  modport sink   (input valid, accepted, found, partner_index, pair_count, total_score,
                  table_full, output ready);
endinterface

/* sv/ppmt_cell.sv */
// One table cell: holds one pair and advances the search token by one place.
module ppmt_cell #(
  parameter int TABLE_DEPTH = 256,
  parameter int INDEX_WIDTH = 16,
  parameter int POS         = 0
) (
  input  logic                                 clk,
  // broadcast command keys
  input  logic [ppmt_pkg::CMD_W-1:0]           cmd,
  input  logic [INDEX_WIDTH-1:0]               key_model,
  input  logic [INDEX_WIDTH-1:0]               key_scene,
  input  logic signed [ppmt_pkg::SCORE_W-1:0]  key_priority,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]     count,
  // search token from the left neighbor
  input  ppmt_pkg::tok_flags_t                 flags_in,
  input  logic [$clog2(TABLE_DEPTH)-1:0]       si_in,
  input  logic [$clog2(TABLE_DEPTH)-1:0]       mi_in,
  input  logic signed [ppmt_pkg::SCORE_W-1:0]  score_s_in,
  input  logic signed [ppmt_pkg::SCORE_W-1:0]  score_m_in,
  input  logic [INDEX_WIDTH-1:0]               partner_in,
  // search token to the right neighbor
  output ppmt_pkg::tok_flags_t                 flags_out,
  output logic [$clog2(TABLE_DEPTH)-1:0]       si_out,
  output logic [$clog2(TABLE_DEPTH)-1:0]       mi_out,
  output logic signed [ppmt_pkg::SCORE_W-1:0]  score_s_out,
  output logic signed [ppmt_pkg::SCORE_W-1:0]  score_m_out,
  output logic [INDEX_WIDTH-1:0]               partner_out,
  // entry update
  input  ppmt_pkg::cell_op_t                   op,
  input  logic [$clog2(TABLE_DEPTH)-1:0]       op_idx,
  input  logic [INDEX_WIDTH-1:0]               wr_model,
  input  logic [INDEX_WIDTH-1:0]               wr_scene,
  input  logic signed [ppmt_pkg::SCORE_W-1:0]  wr_score,
  input  logic signed [ppmt_pkg::SCORE_W-1:0]  wr_priority,
  // entry of the right neighbor, for compaction
  input  logic [INDEX_WIDTH-1:0]               nb_model,
  input  logic [INDEX_WIDTH-1:0]               nb_scene,
  input  logic signed [ppmt_pkg::SCORE_W-1:0]  nb_score,
  input  logic signed [ppmt_pkg::SCORE_W-1:0]  nb_priority,
  // own entry
  output logic [INDEX_WIDTH-1:0]               ent_model,
  output logic [INDEX_WIDTH-1:0]               ent_scene,
  output logic signed [ppmt_pkg::SCORE_W-1:0]  ent_score,
  output logic signed [ppmt_pkg::SCORE_W-1:0]  ent_priority
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] POS_I = IW'(POS);
  localparam logic [CW-1:0] POS_C = CW'(POS);

  logic                 occupied;
  logic                 scene_hit;
  logic                 model_hit;
  logic                 higher;
  ppmt_pkg::tok_flags_t flags_next;
  logic [IW-1:0]        si_next;
  logic [IW-1:0]        mi_next;
  logic signed [ppmt_pkg::SCORE_W-1:0] score_s_next;
  logic signed [ppmt_pkg::SCORE_W-1:0] score_m_next;
  logic [INDEX_WIDTH-1:0] partner_next;

  // Compare own entry against the broadcast keys
  assign occupied  = POS_C < count;
  assign scene_hit = occupied && (ent_scene == key_scene);
  assign model_hit = occupied && !scene_hit && (ent_model == key_model);
  assign higher    = key_priority > ent_priority;

  // Advance the token through this place
  always_comb begin
    flags_next   = flags_in;
    si_next      = si_in;
    mi_next      = mi_in;
    score_s_next = score_s_in;
    score_m_next = score_m_in;
    partner_next = partner_in;
    unique case (cmd)
      ppmt_pkg::CMD_PADD: begin
        if (!flags_in.stop) begin
          if (scene_hit) begin
            si_next          = POS_I;
            score_s_next     = ent_score;
            flags_next.has_s = 1'b1;
            flags_next.can   = higher;
            flags_next.stop  = !higher || flags_in.has_m;
          end else if (model_hit) begin
            mi_next          = POS_I;
            score_m_next     = ent_score;
            flags_next.has_m = 1'b1;
            flags_next.can   = higher;
            flags_next.stop  = !higher || flags_in.has_s;
          end
        end
      end
      ppmt_pkg::CMD_FIND_SCENE: begin
        if (occupied && !flags_in.found && (ent_model == key_model)) begin
          flags_next.found = 1'b1;
          partner_next     = ent_scene;
        end
      end
      ppmt_pkg::CMD_FIND_MODEL: begin
        if (occupied && !flags_in.found && (ent_scene == key_scene)) begin
          flags_next.found = 1'b1;
          partner_next     = ent_model;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold the token for the next cell
  always_ff @(posedge clk) begin
    flags_out   <= flags_next;
    si_out      <= si_next;
    mi_out      <= mi_next;
    score_s_out <= score_s_next;
    score_m_out <= score_m_next;
    partner_out <= partner_next;
  end

  // Overwrite this entry, or take the right neighbor's during compaction
  always_ff @(posedge clk) begin
    if (op == ppmt_pkg::OP_WRITE && op_idx == POS_I) begin
      ent_model    <= wr_model;
      ent_scene    <= wr_scene;
      ent_score    <= wr_score;
      ent_priority <= wr_priority;
    end else if (op == ppmt_pkg::OP_SHIFT && POS_I >= op_idx) begin
      ent_model    <= nb_model;
      ent_scene    <= nb_scene;
      ent_score    <= nb_score;
      ent_priority <= nb_priority;
    end
  end

endmodule

/* sv/ppmt_ctrl.sv */
// Command sequencer: launches the search walk, resolves it and updates count and total.
module ppmt_ctrl #(
  parameter int TABLE_DEPTH = 256,
  parameter int INDEX_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  ppmt_in_if.sink                              item,
  ppmt_out_if.source                           result,
  // broadcast keys
  output logic [ppmt_pkg::CMD_W-1:0]           cmd,
  output logic [INDEX_WIDTH-1:0]               key_model,
  output logic [INDEX_WIDTH-1:0]               key_scene,
  output logic signed [ppmt_pkg::SCORE_W-1:0]  key_score,
  output logic signed [ppmt_pkg::SCORE_W-1:0]  key_priority,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     count,
  // token leaving the last cell
  input  ppmt_pkg::tok_flags_t                 last_flags,
  input  logic [$clog2(TABLE_DEPTH)-1:0]       last_si,
  input  logic [$clog2(TABLE_DEPTH)-1:0]       last_mi,
  input  logic signed [ppmt_pkg::SCORE_W-1:0]  last_score_s,
  input  logic signed [ppmt_pkg::SCORE_W-1:0]  last_score_m,
  input  logic [INDEX_WIDTH-1:0]               last_partner,
  // entry update broadcast
  output ppmt_pkg::cell_op_t                   op,
  output logic [$clog2(TABLE_DEPTH)-1:0]       op_idx
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] WALK_LAST = IW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(TABLE_DEPTH);
  localparam int SW = ppmt_pkg::SUM_W;
  localparam int DW = ppmt_pkg::DELTA_W;

  ppmt_pkg::state_t state, state_next;
  logic [IW-1:0]    wcnt;
  logic signed [SW-1:0] sum;
  logic [IW-1:0]    wr_idx;
  logic [IW-1:0]    rm_idx;
  logic signed [ppmt_pkg::SCORE_W-1:0] rm_score;
  logic signed [DW-1:0] delta;
  logic             rm_pending;
  logic             grow;
  logic             res_accepted;
  logic             res_found;
  logic [INDEX_WIDTH-1:0] res_partner;
  logic             res_full;
  logic             out_valid;
  logic             out_accepted;
  logic             out_found;
  logic [INDEX_WIDTH-1:0] out_partner;
  logic [CW-1:0]    out_count;
  logic signed [SW-1:0] out_total;
  logic             out_full;

  // decision taken at the end of the walk
  logic             do_write;
  logic             do_remove;
  logic             do_grow;
  logic             do_clear;
  logic             dec_accepted;
  logic             dec_full;
  logic [IW-1:0]    dec_idx;
  logic signed [DW-1:0] dec_delta;
  logic             full;
  logic             load_out;

  assign full     = count == DEPTH_C;
  assign load_out = (state == ppmt_pkg::ST_DONE) && (!out_valid || result.ready);

  // Resolve the finished token into a table update
  always_comb begin
    do_write     = 1'b0;
    do_remove    = 1'b0;
    do_grow      = 1'b0;
    do_clear     = 1'b0;
    dec_accepted = 1'b0;
    dec_full     = 1'b0;
    dec_idx      = count[IW-1:0];
    dec_delta    = DW'(key_score);
    unique case (cmd)
      ppmt_pkg::CMD_PADD: begin
        if (last_flags.can) begin
          if (last_flags.has_s) begin
            do_write     = 1'b1;
            do_remove    = last_flags.has_m;
            dec_accepted = 1'b1;
            dec_idx      = last_si;
            dec_delta    = DW'(key_score) - DW'(last_score_s);
          end else if (last_flags.has_m) begin
            do_write     = 1'b1;
            dec_accepted = 1'b1;
            dec_idx      = last_mi;
            dec_delta    = DW'(key_score) - DW'(last_score_m);
          end else if (!full) begin
            do_write     = 1'b1;
            do_grow      = 1'b1;
            dec_accepted = 1'b1;
          end else begin
            dec_full     = 1'b1;
          end
        end
      end
      ppmt_pkg::CMD_APPEND: begin
        if (!full) begin
          do_write     = 1'b1;
          do_grow      = 1'b1;
          dec_accepted = 1'b1;
        end else begin
          dec_full     = 1'b1;
        end
      end
      ppmt_pkg::CMD_CLEAR: begin
        do_clear = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Next state and cell broadcast
  always_comb begin
    state_next = state;
    op         = ppmt_pkg::OP_NONE;
    op_idx     = wr_idx;
    unique case (state)
      ppmt_pkg::ST_IDLE: begin
        if (item.valid) begin
          if (item.cmd == ppmt_pkg::CMD_PADD || item.cmd == ppmt_pkg::CMD_FIND_SCENE ||
              item.cmd == ppmt_pkg::CMD_FIND_MODEL) begin
            state_next = ppmt_pkg::ST_WALK;
          end else begin
            state_next = ppmt_pkg::ST_DECIDE;
          end
        end
      end
      ppmt_pkg::ST_WALK: begin
        if (wcnt == WALK_LAST) begin
          state_next = ppmt_pkg::ST_DECIDE;
        end
      end
      ppmt_pkg::ST_DECIDE: begin
        state_next = do_write ? ppmt_pkg::ST_WRITE : ppmt_pkg::ST_DONE;
      end
      ppmt_pkg::ST_WRITE: begin
        op         = ppmt_pkg::OP_WRITE;
        state_next = rm_pending ? ppmt_pkg::ST_SHIFT : ppmt_pkg::ST_DONE;
      end
      ppmt_pkg::ST_SHIFT: begin
        op         = ppmt_pkg::OP_SHIFT;
        op_idx     = rm_idx;
        state_next = ppmt_pkg::ST_DONE;
      end
      ppmt_pkg::ST_DONE: begin
        if (load_out) begin
          state_next = ppmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ppmt_pkg::ST_IDLE;
      end
    endcase
  end

  assign item.ready = state == ppmt_pkg::ST_IDLE;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppmt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Table count and score total
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
    end else begin
      unique case (state)
        ppmt_pkg::ST_DECIDE: begin
          if (do_clear) begin
            count <= '0;
            sum   <= '0;
          end
        end
        ppmt_pkg::ST_WRITE: begin
          sum <= sum + {{(SW-DW){delta[DW-1]}}, delta};
          if (grow) begin
            count <= count + CW'(1);
          end
        end
        ppmt_pkg::ST_SHIFT: begin
          sum   <= sum - {{(SW-ppmt_pkg::SCORE_W){rm_score[ppmt_pkg::SCORE_W-1]}}, rm_score};
          count <= count - CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Latch the command, advance the walk, record the decision
  always_ff @(posedge clk) begin
    if (state == ppmt_pkg::ST_IDLE && item.valid) begin
      cmd          <= item.cmd;
      key_model    <= item.model_index;
      key_scene    <= item.scene_index;
      key_score    <= item.pair_score;
      key_priority <= (item.cmd == ppmt_pkg::CMD_APPEND) ? '0 : item.pair_priority;
      wcnt         <= '0;
    end else if (state == ppmt_pkg::ST_WALK) begin
      wcnt <= wcnt + IW'(1);
    end
    if (state == ppmt_pkg::ST_DECIDE) begin
      wr_idx       <= dec_idx;
      rm_idx       <= last_mi;
      rm_score     <= last_score_m;
      delta        <= dec_delta;
      rm_pending   <= do_remove;
      grow         <= do_grow;
      res_accepted <= dec_accepted;
      res_full     <= dec_full;
      res_found    <= (cmd == ppmt_pkg::CMD_FIND_SCENE || cmd == ppmt_pkg::CMD_FIND_MODEL) &&
                      last_flags.found;
      res_partner  <= (cmd == ppmt_pkg::CMD_FIND_SCENE || cmd == ppmt_pkg::CMD_FIND_MODEL) &&
                      last_flags.found ? last_partner : '0;
    end
  end

  // Output register: take a new result once the previous one has been transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_accepted <= res_accepted;
      out_found    <= res_found;
      out_partner  <= res_partner;
      out_count    <= count;
      out_total    <= sum;
      out_full     <= res_full;
    end
  end

  assign result.valid         = out_valid;
  assign result.accepted      = out_accepted;
  assign result.found         = out_found;
  assign result.partner_index = out_partner;
  assign result.pair_count    = out_count;
  assign result.total_score   = out_total;
  assign result.table_full    = out_full;

endmodule

/* sv/priority_pair_match_table.sv */
// Pair match table top level: a chain of TABLE_DEPTH cells driven by one sequencer. Each cell
// holds one model/scene pair with its score and priority. A priority add or a lookup sends a
// search token down the chain, one cell per cycle; the sequencer then resolves the walk, writes
// the pair when it is stored and, when a model-clash pair is removed by compaction, has the cell
// of that pair and all cells beyond it take their right neighbor together before the result.
// A plain append skips the walk, and clear and unused codes also skip the write. The next
// command is taken from the cycle after the result is registered, even while that result waits
// to be transferred. Every result carries the pair count and the 48-bit running score total.
module priority_pair_match_table #(
  parameter int TABLE_DEPTH = 256,
  parameter int INDEX_WIDTH = 16
) (
  input logic        clk,
  input logic        rst,
  ppmt_in_if.sink    item,
  ppmt_out_if.source result
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SCW = ppmt_pkg::SCORE_W;

  logic [ppmt_pkg::CMD_W-1:0] cmd;
  logic [INDEX_WIDTH-1:0]     key_model;
  logic [INDEX_WIDTH-1:0]     key_scene;
  logic signed [SCW-1:0]      key_score;
  logic signed [SCW-1:0]      key_priority;
  logic [CW-1:0]              count;
  ppmt_pkg::cell_op_t         op;
  logic [IW-1:0]              op_idx;

  // token chain, place 0 is the fresh token
  ppmt_pkg::tok_flags_t       tok_flags   [TABLE_DEPTH+1];
  logic [IW-1:0]              tok_si      [TABLE_DEPTH+1];
  logic [IW-1:0]              tok_mi      [TABLE_DEPTH+1];
  logic signed [SCW-1:0]      tok_score_s [TABLE_DEPTH+1];
  logic signed [SCW-1:0]      tok_score_m [TABLE_DEPTH+1];
  logic [INDEX_WIDTH-1:0]     tok_partner [TABLE_DEPTH+1];

  // stored entries
  logic [INDEX_WIDTH-1:0]     ent_model    [TABLE_DEPTH];
  logic [INDEX_WIDTH-1:0]     ent_scene    [TABLE_DEPTH];
  logic signed [SCW-1:0]      ent_score    [TABLE_DEPTH];
  logic signed [SCW-1:0]      ent_priority [TABLE_DEPTH];

  assign tok_flags[0]   = ppmt_pkg::TOK_INIT;
  assign tok_si[0]      = '0;
  assign tok_mi[0]      = '0;
  assign tok_score_s[0] = '0;
  assign tok_score_m[0] = '0;
  assign tok_partner[0] = '0;

  ppmt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .result       (result),
    .cmd          (cmd),
    .key_model    (key_model),
    .key_scene    (key_scene),
    .key_score    (key_score),
    .key_priority (key_priority),
    .count        (count),
    .last_flags   (tok_flags[TABLE_DEPTH]),
    .last_si      (tok_si[TABLE_DEPTH]),
    .last_mi      (tok_mi[TABLE_DEPTH]),
    .last_score_s (tok_score_s[TABLE_DEPTH]),
    .last_score_m (tok_score_m[TABLE_DEPTH]),
    .last_partner (tok_partner[TABLE_DEPTH]),
    .op           (op),
    .op_idx       (op_idx)
  );

  // Cell row; the last cell keeps its own entry during compaction
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    localparam int NB = (g < TABLE_DEPTH - 1) ? g + 1 : g;

    ppmt_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .INDEX_WIDTH (INDEX_WIDTH),
      .POS         (g)
    ) u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .key_model    (key_model),
      .key_scene    (key_scene),
      .key_priority (key_priority),
      .count        (count),
      .flags_in     (tok_flags[g]),
      .si_in        (tok_si[g]),
      .mi_in        (tok_mi[g]),
      .score_s_in   (tok_score_s[g]),
      .score_m_in   (tok_score_m[g]),
      .partner_in   (tok_partner[g]),
      .flags_out    (tok_flags[g+1]),
      .si_out       (tok_si[g+1]),
      .mi_out       (tok_mi[g+1]),
      .score_s_out  (tok_score_s[g+1]),
      .score_m_out  (tok_score_m[g+1]),
      .partner_out  (tok_partner[g+1]),
      .op           (op),
      .op_idx       (op_idx),
      .wr_model     (key_model),
      .wr_scene     (key_scene),
      .wr_score     (key_score),
      .wr_priority  (key_priority),
      .nb_model     (ent_model[NB]),
      .nb_scene     (ent_scene[NB]),
      .nb_score     (ent_score[NB]),
      .nb_priority  (ent_priority[NB]),
      .ent_model    (ent_model[g]),
      .ent_scene    (ent_scene[g]),
      .ent_score    (ent_score[g]),
      .ent_priority (ent_priority[g])
    );
  end

  // Count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("pair count beyond table depth");

  // Compaction only directly after an overwrite
  a_shift_after_write: assert property (@(posedge clk) disable iff (rst)
    (op == ppmt_pkg::OP_SHIFT) |-> ($past(op) == ppmt_pkg::OP_WRITE))
    else $error("compaction without a preceding overwrite");

  // No new command while the table is being updated
  a_busy_during_update: assert property (@(posedge clk) disable iff (rst)
    (op != ppmt_pkg::OP_NONE) |-> !item.ready)
    else $error("command taken during a table update");

  // A stored pair and a dropped append never come together
  a_accept_xor_full: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.accepted && result.table_full))
    else $error("result both accepted and full");

endmodule
